// ===== rtl/cas_pkg.sv =====
// ----------------------------------------------------------------------------
// cas_pkg
// Shared widths, register indexes, status codes and reset values of the
// block-cyclic address scatter.
// ----------------------------------------------------------------------------
package cas_pkg;

    localparam int ADDR_W     = 48;
    localparam int LEN_W      = 48;
    localparam int BS_W       = 33;
    localparam int SP_W       = 48;
    localparam int TL_W       = 48;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int STATUS_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SPACING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INEXACT  = 2'd2;

    localparam logic [BS_W-1:0] RST_BLOCK_SIZE    = 33'd1048576;
    localparam logic [SP_W-1:0] RST_BLOCK_SPACING = 48'd8388608;
    localparam logic [TL_W-1:0] RST_TOTAL_LENGTH  = 48'd67108864;

endpackage

// ===== rtl/cas_if.sv =====
// ----------------------------------------------------------------------------
// cas_req_if / cas_chunk_if
// Valid/ready channels for request beats and chunk beats.
// ----------------------------------------------------------------------------
interface cas_req_if;
    import cas_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] request_address;
    logic [LEN_W-1:0]  request_length;

    modport source (output valid, output request_address, output request_length,
                    input ready);
    modport sink   (input valid, input request_address, input request_length,
                    output ready);
endinterface

interface cas_chunk_if;
    import cas_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   chunk_address;
    logic [BS_W-1:0]     chunk_length;
    logic [LEN_W-1:0]    chunk_data_offset;
    logic                chunk_last;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output chunk_address, output chunk_length,
                    output chunk_data_offset, output chunk_last, output status,
                    input ready);
    modport sink   (input valid, input chunk_address, input chunk_length,
                    input chunk_data_offset, input chunk_last, input status,
                    output ready);
endinterface

// ===== rtl/cas_div.sv =====
// ----------------------------------------------------------------------------
// cas_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cas_div #(
    parameter int W = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= W'(trial - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/cas_mul.sv =====
// ----------------------------------------------------------------------------
// cas_mul
// Bit-serial shift-add multiply-accumulate, result modulo 2^W.
// ----------------------------------------------------------------------------
module cas_mul #(
    parameter int W = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] acc_init,
    output logic         done,
    output logic [W-1:0] prod
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  acc_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= acc_init;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/block_cyclic_address_scatter.sv =====
// ----------------------------------------------------------------------------
// block_cyclic_address_scatter
// Cuts an access request at block boundaries and maps each block cyclically
// over the configured columns.
// ----------------------------------------------------------------------------
// Usage:
//   req   : one beat per request (address, length). Ready only when idle.
//   chunk : one beat per chunk, in ascending linear order, last beat marked.
//           A zero-length request gives no beat. A bad configuration or a
//           request needing more than MAX_CHUNKS chunks gives one status beat.
//   cfg   : write cfg_data to register cfg_index when cfg_we is high; only
//           while no request is in flight.
// Passes (operand width max(ADDR_BITS, 48)):
//   configuration check: two serial divides.
//   counting pass: one serial divide per chunk.
//   emitting pass: two divides and two multiplies per chunk, all bit-serial.
// Reset clears the control state and loads the default configuration.
// A stalled chunk beat is held in the output register; the block computes
// the next chunk meanwhile and waits only when that one is ready too.
// ----------------------------------------------------------------------------
module block_cyclic_address_scatter #(
    parameter int MAX_CHUNKS = 64,
    parameter int ADDR_BITS  = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0] cfg_data,
    cas_req_if.sink                      req,
    cas_chunk_if.source                  chunk
);
    import cas_pkg::*;

    localparam int DW    = (ADDR_BITS > 48) ? ADDR_BITS : 48;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CFG1  = 10'b0000000010,
        S_CFG2  = 10'b0000000100,
        S_PDIV  = 10'b0000001000,
        S_EDIV1 = 10'b0000010000,
        S_EDIV2 = 10'b0000100000,
        S_MUL1  = 10'b0001000000,
        S_MUL2  = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_ERR   = 10'b1000000000
    } state_t;

    state_t                state_reg;
    logic [BS_W-1:0]       bs_reg;
    logic [SP_W-1:0]       sp_reg;
    logic [TL_W-1:0]       tl_reg;
    logic [ADDR_BITS-1:0]  addr0_reg;
    logic [LEN_W-1:0]      len0_reg;
    logic [ADDR_BITS-1:0]  cur_reg;
    logic [LEN_W-1:0]      rem_reg;
    logic [LEN_W-1:0]      doff_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DW-1:0]         cycles_reg;
    logic [BS_W-1:0]       inblk_reg;
    logic [BS_W-1:0]       len_reg;
    logic [DW-1:0]         row_reg;
    logic [STATUS_W-1:0]   err_reg;

    logic                  div_go_reg;
    logic [DW-1:0]         div_a_reg;
    logic [DW-1:0]         div_b_reg;
    logic                  mul_go_reg;
    logic [DW-1:0]         mul_a_reg;
    logic [DW-1:0]         mul_b_reg;
    logic [DW-1:0]         mul_c_reg;

    logic                  ov_reg;
    logic [ADDR_W-1:0]     o_addr_reg;
    logic [BS_W-1:0]       o_len_reg;
    logic [LEN_W-1:0]      o_doff_reg;
    logic                  o_last_reg;
    logic [STATUS_W-1:0]   o_status_reg;

    logic                  div_done;
    logic [DW-1:0]         div_quo;
    logic [DW-1:0]         div_rem;
    logic                  mul_done;
    logic [DW-1:0]         mul_prod;

    logic [BS_W-1:0]       room;
    logic [BS_W-1:0]       p_len;
    logic [ADDR_BITS-1:0]  cur_p;
    logic [ADDR_BITS-1:0]  cur_e;
    logic [DW-1:0]         req_addr_ext;
    logic [DW-1:0]         out_addr_ext;
    logic                  out_free;
    logic                  e_last;

    cas_div #(.W(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    cas_mul #(.W(DW)) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_go_reg),
        .a        (mul_a_reg),
        .b        (mul_b_reg),
        .acc_init (mul_c_reg),
        .done     (mul_done),
        .prod     (mul_prod)
    );

    assign room         = bs_reg - div_rem[BS_W-1:0];
    assign p_len        = (rem_reg < LEN_W'(room)) ? rem_reg[BS_W-1:0] : room;
    assign cur_p        = cur_reg + ADDR_BITS'(p_len);
    assign cur_e        = cur_reg + ADDR_BITS'(len_reg);
    assign req_addr_ext = DW'(req.request_address);
    assign out_addr_ext = DW'(mul_prod[ADDR_BITS-1:0]);
    assign out_free     = !ov_reg || chunk.ready;
    assign e_last       = rem_reg == LEN_W'(len_reg);

    assign req.ready               = (state_reg == S_IDLE);
    assign chunk.valid             = ov_reg;
    assign chunk.chunk_address     = o_addr_reg;
    assign chunk.chunk_length      = o_len_reg;
    assign chunk.chunk_data_offset = o_doff_reg;
    assign chunk.chunk_last        = o_last_reg;
    assign chunk.status            = o_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg <= RST_BLOCK_SIZE;
            sp_reg <= RST_BLOCK_SPACING;
            tl_reg <= RST_TOTAL_LENGTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE:    bs_reg <= cfg_data[BS_W-1:0];
                REG_BLOCK_SPACING: sp_reg <= cfg_data[SP_W-1:0];
                REG_TOTAL_LENGTH:  tl_reg <= cfg_data[TL_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            div_go_reg <= 1'b0;
            mul_go_reg <= 1'b0;
            ov_reg     <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            mul_go_reg <= 1'b0;
            if (ov_reg && chunk.ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (req.request_length != '0)
                        begin
                            if (bs_reg == '0 || sp_reg == '0)
                            begin
                                err_reg   <= ST_INEXACT;
                                state_reg <= S_ERR;
                            end
                            else
                            begin
                                div_go_reg <= 1'b1;
                                div_a_reg  <= DW'(tl_reg);
                                div_b_reg  <= DW'(sp_reg);
                                state_reg  <= S_CFG1;
                            end
                        end
                    end
                end
                S_CFG1:
                begin
                    if (div_done)
                    begin
                        cycles_reg <= div_quo;
                        if (div_quo == '0 || div_rem != '0)
                        begin
                            err_reg   <= ST_INEXACT;
                            state_reg <= S_ERR;
                        end
                        else
                        begin
                            div_go_reg <= 1'b1;
                            div_a_reg  <= DW'(sp_reg);
                            div_b_reg  <= DW'(bs_reg);
                            state_reg  <= S_CFG2;
                        end
                    end
                end
                S_CFG2:
                begin
                    if (div_done)
                    begin
                        if (div_rem != '0)
                        begin
                            err_reg   <= ST_INEXACT;
                            state_reg <= S_ERR;
                        end
                        else
                        begin
                            cur_reg    <= addr0_reg;
                            rem_reg    <= len0_reg;
                            cnt_reg    <= '0;
                            div_go_reg <= 1'b1;
                            div_a_reg  <= DW'(addr0_reg);
                            div_b_reg  <= DW'(bs_reg);
                            state_reg  <= S_PDIV;
                        end
                    end
                end
                S_PDIV:
                begin
                    if (div_done)
                    begin
                        if (cnt_reg == CNT_W'(MAX_CHUNKS))
                        begin
                            err_reg   <= ST_TOO_MANY;
                            state_reg <= S_ERR;
                        end
                        else
                        begin
                            cnt_reg    <= cnt_reg + 1'b1;
                            div_go_reg <= 1'b1;
                            div_b_reg  <= DW'(bs_reg);
                            if (rem_reg == LEN_W'(p_len))
                            begin
                                cur_reg   <= addr0_reg;
                                rem_reg   <= len0_reg;
                                doff_reg  <= '0;
                                div_a_reg <= DW'(addr0_reg);
                                state_reg <= S_EDIV1;
                            end
                            else
                            begin
                                cur_reg   <= cur_p;
                                rem_reg   <= rem_reg - LEN_W'(p_len);
                                div_a_reg <= DW'(cur_p);
                            end
                        end
                    end
                end
                S_EDIV1:
                begin
                    if (div_done)
                    begin
                        inblk_reg  <= div_rem[BS_W-1:0];
                        len_reg    <= p_len;
                        div_go_reg <= 1'b1;
                        div_a_reg  <= div_quo;
                        div_b_reg  <= cycles_reg;
                        state_reg  <= S_EDIV2;
                    end
                end
                S_EDIV2:
                begin
                    if (div_done)
                    begin
                        row_reg    <= div_quo;
                        mul_go_reg <= 1'b1;
                        mul_a_reg  <= div_rem;
                        mul_b_reg  <= DW'(sp_reg);
                        mul_c_reg  <= DW'(inblk_reg);
                        state_reg  <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    if (mul_done)
                    begin
                        mul_go_reg <= 1'b1;
                        mul_a_reg  <= row_reg;
                        mul_b_reg  <= DW'(bs_reg);
                        mul_c_reg  <= mul_prod;
                        state_reg  <= S_MUL2;
                    end
                end
                S_MUL2:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg       <= 1'b1;
                        o_addr_reg   <= out_addr_ext[ADDR_W-1:0];
                        o_len_reg    <= len_reg;
                        o_doff_reg   <= doff_reg;
                        o_last_reg   <= e_last;
                        o_status_reg <= ST_OK;
                        doff_reg     <= doff_reg + LEN_W'(len_reg);
                        cur_reg      <= cur_e;
                        rem_reg      <= rem_reg - LEN_W'(len_reg);
                        if (e_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            div_go_reg <= 1'b1;
                            div_a_reg  <= DW'(cur_e);
                            div_b_reg  <= DW'(bs_reg);
                            state_reg  <= S_EDIV1;
                        end
                    end
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        ov_reg       <= 1'b1;
                        o_addr_reg   <= '0;
                        o_len_reg    <= '0;
                        o_doff_reg   <= '0;
                        o_last_reg   <= 1'b1;
                        o_status_reg <= err_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid)
        begin
            addr0_reg <= req_addr_ext[ADDR_BITS-1:0];
            len0_reg  <= req.request_length;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_CHUNKS))
        else $error("chunk count beyond limit");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");

    a_emit_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> len_reg != '0)
        else $error("empty chunk about to be sent");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && o_status_reg != ST_OK |-> o_last_reg && o_len_reg == '0)
        else $error("status beat not final or not empty");

endmodule

// ===== bench/tb_block_cyclic_address_scatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_cyclic_address_scatter
// Sends access requests through several block/spacing/length settings,
// predicts the cyclic chunk beats of each request and checks every chunk beat
// against them in order, under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_block_cyclic_address_scatter;
    import cas_pkg::*;

    localparam longint unsigned M48       = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned M33       = 64'h1_FFFF_FFFF;
    localparam int              CHUNK_MAX = 64;
    localparam int              STALL_MAX = 50000;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [BS_W-1:0]     len;
        logic [LEN_W-1:0]    off;
        logic                last;
        logic [STATUS_W-1:0] st;
    } chunk_beat_t;

    class chunk_scoreboard;
        longint unsigned block_size;
        longint unsigned block_spacing;
        longint unsigned total_length;
        chunk_beat_t     pending_chunks[$];
        int              errors;

        function new();
            block_size    = RST_BLOCK_SIZE;
            block_spacing = RST_BLOCK_SPACING;
            total_length  = RST_TOTAL_LENGTH;
            errors        = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
            if (idx == REG_BLOCK_SIZE)
                block_size = val & M33;
            else if (idx == REG_BLOCK_SPACING)
                block_spacing = val & M48;
            else if (idx == REG_TOTAL_LENGTH)
                total_length = val & M48;
        endfunction

        function void add_beat(chunk_beat_t b);
            pending_chunks.insert(pending_chunks.size(), b);
        endfunction

        function chunk_beat_t status_beat(logic [STATUS_W-1:0] code);
            chunk_beat_t b;
            b      = '0;
            b.last = 1'b1;
            b.st   = code;
            return b;
        endfunction

        function void note_request(longint unsigned a, longint unsigned l);
            longint unsigned cur, rem, off, cyc, per, bidx, inb, room, ln;
            int              n;
            chunk_beat_t     b;
            chunk_beat_t     tmp[$];
            cur = a & M48;
            rem = l & M48;
            off = 0;
            n   = 0;
            if (rem == 0)
                return;
            cyc = 0;
            per = 0;
            if (block_size != 0 && block_spacing != 0) begin
                cyc = total_length / block_spacing;
                per = block_spacing / block_size;
            end
            if (cyc == 0 || cyc * block_spacing != total_length ||
                cyc * per * block_size != total_length) begin
                add_beat(status_beat(ST_INEXACT));
                return;
            end
            while (rem > 0 && n < CHUNK_MAX) begin
                bidx   = cur / block_size;
                inb    = cur % block_size;
                room   = block_size - inb;
                ln     = (room < rem) ? room : rem;
                b      = '0;
                b.addr = ((bidx % cyc) * block_spacing + (bidx / cyc) * block_size + inb) & M48;
                b.len  = ln & M33;
                b.off  = off & M48;
                b.st   = ST_OK;
                tmp.insert(tmp.size(), b);
                n++;
                off = (off + ln) & M48;
                cur = (cur + ln) & M48;
                rem -= ln;
            end
            if (rem > 0) begin
                add_beat(status_beat(ST_TOO_MANY));
                return;
            end
            tmp[tmp.size()-1].last = 1'b1;
            foreach (tmp[i])
                add_beat(tmp[i]);
        endfunction

        function void check_chunk(chunk_beat_t act);
            chunk_beat_t exp_b;
            if (pending_chunks.size() == 0) begin
                $display("%0t: unexpected chunk beat %h", $realtime, act);
                errors++;
                return;
            end
            exp_b = pending_chunks.pop_front();
            if (exp_b.addr != act.addr || exp_b.len != act.len || exp_b.off != act.off ||
                exp_b.last != act.last || exp_b.st != act.st) begin
                $display("%0t: chunk mismatch exp addr=%h len=%h off=%h last=%b st=%0d",
                         $realtime, exp_b.addr, exp_b.len, exp_b.off, exp_b.last, exp_b.st);
                $display("%0t:                act addr=%h len=%h off=%h last=%b st=%0d",
                         $realtime, act.addr, act.len, act.off, act.last, act.st);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cas_req_if   req ();
    cas_chunk_if chunk ();

    block_cyclic_address_scatter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .chunk     (chunk.source)
    );

    chunk_scoreboard sb;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              quiet_cycles;
    longint unsigned cur_bs;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        chunk.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (chunk.valid && chunk.ready)
                sb.check_chunk({chunk.chunk_address, chunk.chunk_length,
                                chunk.chunk_data_offset, chunk.chunk_last, chunk.status});
            if ((chunk.valid && chunk.ready) || (req.valid && req.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic load_config(longint unsigned bs, longint unsigned sp, longint unsigned tl);
        write_reg(REG_BLOCK_SIZE, bs);
        write_reg(REG_BLOCK_SPACING, sp);
        write_reg(REG_TOTAL_LENGTH, tl);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_bs = bs & M33;
    endtask

    task automatic send_request(longint unsigned a, longint unsigned l);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req.valid           <= 1'b1;
        req.request_address <= a[ADDR_W-1:0];
        req.request_length  <= l[LEN_W-1:0];
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(a & M48, l & M48);
    endtask

    // drain, then allow for a zero-length beat still being absorbed
    task automatic wait_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_chunks.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    function automatic longint unsigned rand48();
        return {$urandom, $urandom} & M48;
    endfunction

    task automatic send_random();
        longint unsigned a, l, bs;
        int              r;
        bs = (cur_bs == 0) ? 64'd16 : cur_bs;
        r  = $urandom_range(99);
        a  = rand48();
        if (r < 8)
            l = 0;
        else if (r < 16)
            l = rand48();
        else if (r < 19)
            l = (bs * CHUNK_MAX - a % bs + $urandom_range(1)) & M48;
        else
            l = 1 + rand48() % (bs * 3);
        send_request(a, l);
    endtask

    initial
    begin
        longint unsigned cfgs[6][3];
        sb                  = new();
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        req.valid           = 1'b0;
        req.request_address = '0;
        req.request_length  = '0;
        chunk.ready         = 1'b0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        quiet_cycles        = 0;
        cur_bs              = RST_BLOCK_SIZE;
        cfgs = '{'{64'd16, 64'd64, 64'd256},
                 '{RST_BLOCK_SIZE, RST_BLOCK_SPACING, RST_TOTAL_LENGTH},
                 '{64'h1_0000_0000, 64'h100_0000_0000, 64'h8000_0000_0000},
                 '{64'd1, M48, M48},
                 '{64'd3, 64'd8, 64'd16},
                 '{64'd0, 64'd64, 64'd256}};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers first, untouched
        for (int i = 0; i < 6; i++)
            send_random();
        wait_idle();

        load_config(16, 64, 256);
        send_request(0, 0);
        send_request(0, 1);
        send_request(M48, 1);
        send_request(M48, 2);
        send_request(M48, M48);
        send_request(0, 16 * 64);
        send_request(0, 16 * 64 + 1);
        send_request(15, 2);
        send_request(64'hAAAA_AAAA_AAAA, 17);
        send_request(64'h5555_5555_5555, 33);
        send_request(255, 3);
        send_request(256, 16);
        send_request(1, 16 * 64 - 1);
        send_request(64'h5555_5555_5555, 0);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            load_config(cfgs[p][0], cfgs[p][1], cfgs[p][2]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            for (int i = 0; i < 18; i++) begin
                send_random();
                if (i == 9 && p == 1)
                    wait_idle();
            end
            wait_idle();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_idle();

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cas_pkg.sv
rtl/cas_if.sv
rtl/cas_div.sv
rtl/cas_mul.sv
rtl/block_cyclic_address_scatter.sv
bench/tb_block_cyclic_address_scatter.sv
